// File: src/derivative_product_poly_engine_macros.svh
// Assertion helpers shared by the engine. Each use names its label, its
// trigger, its consequence and the message that is reported.
`ifndef DERIVATIVE_PRODUCT_POLY_ENGINE_MACROS_SVH
`define DERIVATIVE_PRODUCT_POLY_ENGINE_MACROS_SVH

// The consequence must hold in the same cycle as the trigger.
`define DPPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define DPPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dppe_pkg.sv
package dppe_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int COEFF_W    = 64;
    localparam int DATA_W     = 64;
    localparam int OP_W       = 3;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int TABLE_SIZE = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    // Produced terms may reach two orders past the last stored one.
    localparam int ORD_W      = $clog2(MAX_ORDER + 2);
    localparam int PROD_W     = 2 * ORD_W;

    localparam logic [OP_W-1:0] OP_ADD   = OP_W'(0);
    localparam logic [OP_W-1:0] OP_DIFF  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_DDIFF = OP_W'(2);
    localparam logic [OP_W-1:0] OP_READ  = OP_W'(3);
    localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(4);

    localparam logic [STATUS_W-1:0] ST_OK  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_BAD = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_OVF = STATUS_W'(2);

    typedef logic [COEFF_W-1:0]       coeff_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic [ORD_W-1:0]         ord_t;

    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        logic   bank;
        slot_t  slot;
        coeff_t wdata;
        logic   clr_en;
        logic   clr_bank;
    } store_cmd_t;

    // First slot of the row whose larger order is h.
    function automatic slot_t tri_base(input ord_t h);
        logic [PROD_W-1:0] p;
        p = PROD_W'(h) * (PROD_W'(h) + PROD_W'(1));
        return SLOT_W'(p >> 1);
    endfunction

endpackage

// File: src/dppe_if.sv
interface dppe_req_if import dppe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [IDX_W-1:0]    index_first;
    logic [IDX_W-1:0]    index_second;
    logic signed [63:0]  term_coefficient;

    modport source (output valid, output operation, output index_first,
                    output index_second, output term_coefficient, input ready);
    modport sink   (input valid, input operation, input index_first,
                    input index_second, input term_coefficient, output ready);
endinterface

interface dppe_rsp_if import dppe_pkg::*; ();
    logic                valid;
    logic                ready;
    data_t               read_coefficient;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output read_coefficient, output status, input ready);
    modport sink   (input valid, input read_coefficient, input status, output ready);
endinterface

// File: src/derivative_product_poly_engine.sv
// Derivative product polynomial engine: a triangular table of coefficients for
// products of two derivative orders, kept in two banks of a single-port table
// memory with registered reads, and worked on one item at a time by a small
// sequencer. Every read-modify-write reads the entry in a read state and writes
// the new value back in a write-back state; a differentiate visits every stored
// entry and adds each produced term into the other bank. The table is empty
// right after reset, with no clearing pass. The block takes a new item while
// the previous result still waits to be taken.
`include "derivative_product_poly_engine_macros.svh"

module derivative_product_poly_engine import dppe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    dppe_req_if.sink   req,
    dppe_rsp_if.source rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ARD   = 4'd1;
    localparam logic [3:0] S_AWB   = 4'd2;
    localparam logic [3:0] S_DCLR  = 4'd3;
    localparam logic [3:0] S_DSRD  = 4'd4;
    localparam logic [3:0] S_DSW   = 4'd5;
    localparam logic [3:0] S_DTERM = 4'd6;
    localparam logic [3:0] S_DWB   = 4'd7;
    localparam logic [3:0] S_FLIP  = 4'd8;
    localparam logic [3:0] S_RB    = 4'd9;
    localparam logic [3:0] S_RBW   = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic                active_bank_reg, active_bank_next;
    logic                ovf_reg, ovf_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [OP_W-1:0]     op_reg, op_next;
    slot_t               item_slot_reg, item_slot_next;
    logic                in_range_reg, in_range_next;
    logic                bad_reg, bad_next;
    coeff_t              coeff_reg, coeff_next;
    ord_t                a_reg, a_next;
    ord_t                b_reg, b_next;
    slot_t               src_slot_reg, src_slot_next;
    logic [1:0]          k_reg, k_next;
    coeff_t              c_reg, c_next;
    slot_t               dst_slot_reg, dst_slot_next;
    coeff_t              tcoef_reg, tcoef_next;
    data_t               rsp_coef_reg, rsp_coef_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;

    store_cmd_t          store_cmd;
    coeff_t              rdata;

    logic [IDX_W-1:0]    req_lo, req_hi;
    logic                req_in_range;
    logic                twice;
    ord_t                t_x, t_y, t_lo, t_hi;
    coeff_t              tc;
    logic                t_ovf;
    slot_t               t_slot;
    logic                k_last, src_last;
    logic                term_done, src_done;
    coeff_t              rb_value;

    dppe_bank_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (store_cmd),
        .rdata (rdata)
    );

    assign req_lo       = (req.index_first < req.index_second) ? req.index_first
                                                                : req.index_second;
    assign req_hi       = (req.index_first < req.index_second) ? req.index_second
                                                                : req.index_first;
    assign req_in_range = req_hi < IDX_W'(MAX_ORDER);
    assign req.ready    = (state_reg == S_IDLE);

    // Terms produced from the source entry (a, b) by the Leibniz rule.
    assign twice = (op_reg == OP_DDIFF);

    always_comb
    begin
        t_x = a_reg;
        t_y = b_reg;
        tc  = c_reg;
        if (twice)
        begin
            case (k_reg)
                2'd0:
                begin
                    t_x = a_reg + ORD_W'(2);
                end
                2'd1:
                begin
                    t_x = a_reg + ORD_W'(1);
                    t_y = b_reg + ORD_W'(1);
                    tc  = c_reg << 1;
                end
                default:
                begin
                    t_y = b_reg + ORD_W'(2);
                end
            endcase
        end
        else
        begin
            case (k_reg)
                2'd0:    t_x = a_reg + ORD_W'(1);
                default: t_y = b_reg + ORD_W'(1);
            endcase
        end
    end

    assign t_lo     = (t_x < t_y) ? t_x : t_y;
    assign t_hi     = (t_x < t_y) ? t_y : t_x;
    assign t_ovf    = t_hi >= ORD_W'(MAX_ORDER);
    assign t_slot   = tri_base(t_hi) + SLOT_W'(t_lo);
    assign k_last   = twice ? (k_reg == 2'd2) : (k_reg == 2'd1);
    assign src_last = (b_reg == ORD_W'(MAX_ORDER - 1)) && (a_reg == b_reg);
    assign rb_value = (in_range_reg && !bad_reg) ? rdata : '0;

    always_comb
    begin
        state_next       = state_reg;
        active_bank_next = active_bank_reg;
        ovf_next         = ovf_reg;
        rsp_valid_next   = rsp_valid_reg;
        op_next          = op_reg;
        item_slot_next   = item_slot_reg;
        in_range_next    = in_range_reg;
        bad_next         = bad_reg;
        coeff_next       = coeff_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        src_slot_next    = src_slot_reg;
        k_next           = k_reg;
        c_next           = c_reg;
        dst_slot_next    = dst_slot_reg;
        tcoef_next       = tcoef_reg;
        rsp_coef_next    = rsp_coef_reg;
        rsp_status_next  = rsp_status_reg;
        term_done        = 1'b0;
        src_done         = 1'b0;

        store_cmd          = '0;
        store_cmd.bank     = active_bank_reg;
        store_cmd.slot     = item_slot_reg;
        store_cmd.clr_bank = active_bank_reg;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.operation;
                    item_slot_next = tri_base(ORD_W'(req_hi)) + SLOT_W'(req_lo);
                    in_range_next  = req_in_range;
                    coeff_next     = req.term_coefficient[COEFF_W-1:0];
                    bad_next       = 1'b0;
                    unique case (req.operation) inside
                        OP_ADD:
                        begin
                            if (req_in_range)
                                state_next = S_ARD;
                            else
                            begin
                                bad_next   = 1'b1;
                                state_next = S_RB;
                            end
                        end
                        OP_READ:
                        begin
                            bad_next   = !req_in_range;
                            state_next = S_RB;
                        end
                        OP_DIFF, OP_DDIFF:
                        begin
                            state_next = S_DCLR;
                        end
                        OP_CLEAR:
                        begin
                            store_cmd.clr_en = 1'b1;
                            ovf_next         = 1'b0;
                            state_next       = S_RB;
                        end
                        default:
                        begin
                            state_next = S_RB;
                        end
                    endcase
                end
            end
            S_ARD:
            begin
                store_cmd.rd_en = 1'b1;
                state_next      = S_AWB;
            end
            S_AWB:
            begin
                store_cmd.wr_en = 1'b1;
                store_cmd.wdata = (coeff_reg == '0) ? '0 : rdata + coeff_reg;
                state_next      = S_RB;
            end
            S_DCLR:
            begin
                // The target bank starts empty.
                store_cmd.clr_en   = 1'b1;
                store_cmd.clr_bank = !active_bank_reg;
                a_next             = '0;
                b_next             = '0;
                src_slot_next      = '0;
                state_next         = S_DSRD;
            end
            S_DSRD:
            begin
                store_cmd.rd_en = 1'b1;
                store_cmd.slot  = src_slot_reg;
                state_next      = S_DSW;
            end
            S_DSW:
            begin
                c_next = rdata;
                k_next = '0;
                if (rdata == '0)
                    src_done = 1'b1;
                else
                    state_next = S_DTERM;
            end
            S_DTERM:
            begin
                if (t_ovf)
                begin
                    if (tc != '0)
                        ovf_next = 1'b1;
                    term_done = 1'b1;
                end
                else
                begin
                    store_cmd.rd_en = 1'b1;
                    store_cmd.bank  = !active_bank_reg;
                    store_cmd.slot  = t_slot;
                    dst_slot_next   = t_slot;
                    tcoef_next      = tc;
                    state_next      = S_DWB;
                end
            end
            S_DWB:
            begin
                store_cmd.wr_en = 1'b1;
                store_cmd.bank  = !active_bank_reg;
                store_cmd.slot  = dst_slot_reg;
                store_cmd.wdata = rdata + tcoef_reg;
                term_done       = 1'b1;
            end
            S_FLIP:
            begin
                active_bank_next = !active_bank_reg;
                state_next       = S_RB;
            end
            S_RB:
            begin
                store_cmd.rd_en = in_range_reg && !bad_reg;
                state_next      = S_RBW;
            end
            S_RBW:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_coef_next   = DATA_W'($signed(rb_value));
                    rsp_status_next = bad_reg ? ST_BAD : (ovf_reg ? ST_OVF : ST_OK);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (term_done)
        begin
            if (k_last)
                src_done = 1'b1;
            else
            begin
                k_next     = k_reg + 2'd1;
                state_next = S_DTERM;
            end
        end

        if (src_done)
        begin
            if (src_last)
                state_next = S_FLIP;
            else
            begin
                if (a_reg == b_reg)
                begin
                    a_next = '0;
                    b_next = b_reg + ORD_W'(1);
                end
                else
                    a_next = a_reg + ORD_W'(1);
                src_slot_next = src_slot_reg + SLOT_W'(1);
                state_next    = S_DSRD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_bank_reg <= 1'b0;
            ovf_reg         <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_bank_reg <= active_bank_next;
            ovf_reg         <= ovf_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        item_slot_reg  <= item_slot_next;
        in_range_reg   <= in_range_next;
        bad_reg        <= bad_next;
        coeff_reg      <= coeff_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        src_slot_reg   <= src_slot_next;
        k_reg          <= k_next;
        c_reg          <= c_next;
        dst_slot_reg   <= dst_slot_next;
        tcoef_reg      <= tcoef_next;
        rsp_coef_reg   <= rsp_coef_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.read_coefficient = rsp_coef_reg;
    assign rsp.status           = rsp_status_reg;

    `DPPE_ASSERT_IMP(a_bad_reads_zero, rsp.valid && rsp.status == ST_BAD, rsp.read_coefficient == '0, "flagged index with nonzero coefficient")
    `DPPE_ASSERT_IMP(a_write_states, store_cmd.wr_en, state_reg == S_AWB || state_reg == S_DWB, "table write outside a write-back state")
    `DPPE_ASSERT_IMP(a_single_access, store_cmd.wr_en, !store_cmd.rd_en, "table read and write in the same cycle")
    `DPPE_ASSERT_NXT(a_bank_flip, state_reg == S_FLIP, active_bank_reg != $past(active_bank_reg), "bank did not switch after differentiation")
    `DPPE_ASSERT_IMP(a_ovf_source, $rose(ovf_reg), $past(state_reg) == S_DTERM, "overflow status set outside term generation")

endmodule

// File: src/dppe_bank_store.sv
module dppe_bank_store import dppe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_cmd_t cmd,
    output coeff_t     rdata
);

    coeff_t                  coeff_a_reg [TABLE_SIZE];
    coeff_t                  coeff_b_reg [TABLE_SIZE];
    coeff_t                  rd_data_reg;
    logic [TABLE_SIZE-1:0]   valid_a_reg;
    logic [TABLE_SIZE-1:0]   valid_b_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            if (cmd.bank)
                coeff_b_reg[cmd.slot] <= cmd.wdata;
            else
                coeff_a_reg[cmd.slot] <= cmd.wdata;
        end
        if (cmd.rd_en)
            rd_data_reg <= cmd.bank ? coeff_b_reg[cmd.slot] : coeff_a_reg[cmd.slot];
    end

    // Entries that were never written since the last clear read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg  <= '0;
            valid_b_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                if (cmd.clr_bank)
                    valid_b_reg <= '0;
                else
                    valid_a_reg <= '0;
            end
            if (cmd.wr_en)
            begin
                if (cmd.bank)
                    valid_b_reg[cmd.slot] <= 1'b1;
                else
                    valid_a_reg[cmd.slot] <= 1'b1;
            end
            if (cmd.rd_en)
                rd_valid_reg <= cmd.bank ? valid_b_reg[cmd.slot] : valid_a_reg[cmd.slot];
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: test/poly_table_checker.sv
module poly_table_checker import dppe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dppe_req_if  req,
    dppe_rsp_if  rsp,
    output int   mismatch_count,
    output int   readbacks_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        data_t               coefficient;
        logic [STATUS_W-1:0] status;
    } readback_t;

    coeff_t    live_table [TABLE_SIZE];
    coeff_t    derived_table [TABLE_SIZE];
    logic      overflow_sticky;
    readback_t expected_readbacks [$];
    readback_t oldest;

    function automatic int term_slot(input int lo, input int hi);
        return hi * (hi + 1) / 2 + lo;
    endfunction

    // A produced term past the last order is lost; only a nonzero one marks overflow.
    function automatic void deposit_term(input int x, input int y, input coeff_t c);
        int lo;
        int hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        if (hi >= MAX_ORDER)
        begin
            if (c != '0)
                overflow_sticky = 1'b1;
        end
        else
        begin
            derived_table[term_slot(lo, hi)] = derived_table[term_slot(lo, hi)] + c;
        end
    endfunction

    function automatic void apply_leibniz(input bit twice);
        coeff_t c;
        foreach (derived_table[i])
            derived_table[i] = '0;
        for (int hi = 0; hi < MAX_ORDER; hi++)
        begin
            for (int lo = 0; lo <= hi; lo++)
            begin
                c = live_table[term_slot(lo, hi)];
                if (c != '0)
                begin
                    if (twice)
                    begin
                        deposit_term(lo + 2, hi, c);
                        deposit_term(lo + 1, hi + 1, c << 1);
                        deposit_term(lo, hi + 2, c);
                    end
                    else
                    begin
                        deposit_term(lo + 1, hi, c);
                        deposit_term(lo, hi + 1, c);
                    end
                end
            end
        end
        live_table = derived_table;
    endfunction

    function automatic readback_t predict_poly_op(input logic [OP_W-1:0] op,
                                                  input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y,
                                                  input coeff_t coef);
        readback_t r;
        int        lo;
        int        hi;
        bit        in_range;
        bit        bad_index;
        lo = (x < y) ? int'(x) : int'(y);
        hi = (x < y) ? int'(y) : int'(x);
        in_range = (hi < MAX_ORDER);
        bad_index = 1'b0;
        case (op)
            OP_ADD:
            begin
                if (!in_range)
                    bad_index = 1'b1;
                else if (coef == '0)
                    live_table[term_slot(lo, hi)] = '0;
                else
                    live_table[term_slot(lo, hi)] = live_table[term_slot(lo, hi)] + coef;
            end
            OP_DIFF:  apply_leibniz(1'b0);
            OP_DDIFF: apply_leibniz(1'b1);
            OP_READ:
            begin
                if (!in_range)
                    bad_index = 1'b1;
            end
            OP_CLEAR:
            begin
                foreach (live_table[i])
                    live_table[i] = '0;
                overflow_sticky = 1'b0;
            end
            default: ;
        endcase
        r.coefficient = '0;
        if (in_range && !bad_index)
            r.coefficient = data_t'(live_table[term_slot(lo, hi)]);
        r.status = bad_index ? ST_BAD : (overflow_sticky ? ST_OVF : ST_OK);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (live_table[i])
                live_table[i] = '0;
            overflow_sticky = 1'b0;
            expected_readbacks.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_readbacks.push_back(predict_poly_op(req.operation, req.index_first,
                                                             req.index_second,
                                                             req.term_coefficient));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_readbacks.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual coefficient %h status %0d",
                             $time, rsp.read_coefficient, rsp.status);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_readbacks.pop_front();
                    if (rsp.read_coefficient !== oldest.coefficient)
                    begin
                        $display("%0t: read_coefficient mismatch: expected %h actual %h",
                                 $time, oldest.coefficient, rsp.read_coefficient);
                        mismatch_count++;
                    end
                    if (rsp.status !== oldest.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, oldest.status, rsp.status);
                        mismatch_count++;
                    end
                end
            end
        end
        readbacks_pending = expected_readbacks.size();
    end

endmodule

// File: test/tb_top.sv
module tb_top import dppe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 1170;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 1200;
    localparam int CYCLE_LIMIT  = 6_000_000;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(5);
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = OP_W'(7);

    localparam logic signed [63:0] COEF_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] COEF_MIN = 64'sh8000_0000_0000_0000;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_allowed = 1'b1;
    int   cycle_count = 0;
    int   mismatch_count;
    int   readbacks_pending;

    dppe_req_if req_ch();
    dppe_rsp_if rsp_ch();

    derivative_product_poly_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    poly_table_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .mismatch_count    (mismatch_count),
        .readbacks_pending (readbacks_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic pause_sender();
        if (idle_allowed && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] x,
                           input logic [IDX_W-1:0] y, input logic signed [63:0] c);
        pause_sender();
        req_ch.valid            <= 1'b1;
        req_ch.operation        <= op;
        req_ch.index_first      <= x;
        req_ch.index_second     <= y;
        req_ch.term_coefficient <= c;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function automatic logic signed [63:0] random_coefficient();
        int modest;
        modest = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COEF_MAX;
            2:       return COEF_MIN;
            3:       return -64'sd1;
            4, 5:    return 64'(modest);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly orders that fit the table, now and then any byte at all.
    function automatic logic [IDX_W-1:0] random_index();
        if ($urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 255));
        return IDX_W'($urandom_range(0, MAX_ORDER - 1));
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return OP_ADD;
        if (pick < 78)
            return OP_READ;
        if (pick < 86)
            return OP_DIFF;
        if (pick < 92)
            return OP_DDIFF;
        if (pick < 96)
            return OP_CLEAR;
        return OP_W'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
    endfunction

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (idle_allowed && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** derivative_product_poly_engine: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n                   <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.operation        <= OP_ADD;
        req_ch.index_first      <= '0;
        req_ch.index_second     <= '0;
        req_ch.term_coefficient <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_op(OP_READ, 0, 0, 0);
        send_op(OP_ADD, 3, 1, COEF_MAX);
        send_op(OP_READ, 1, 3, 0);
        send_op(OP_ADD, 1, 3, 1);
        send_op(OP_ADD, 15, 15, -64'sd1);
        send_op(OP_ADD, 0, 0, 5);
        send_op(OP_ADD, 0, 0, 0);
        send_op(OP_ADD, 16, 2, 9);
        send_op(OP_READ, 255, 0, 0);
        send_op(OP_ADD, 0, 0, 7);
        // The corner entry pushes past the last order here.
        send_op(OP_DIFF, 1, 0, 0);
        send_op(OP_READ, 0, 1, 0);
        send_op(OP_DDIFF, 200, 3, 0);
        send_op(OP_CLEAR, 0, 0, 0);
        send_op(OP_ADD, 14, 14, 3);
        send_op(OP_DDIFF, 15, 15, 0);
        send_op(OP_READ, 255, 255, -64'sd1);
        send_op(OP_CLEAR, 7, 7, 0);
        // Doubling the most negative value wraps the middle term to zero.
        send_op(OP_ADD, 0, 0, COEF_MIN);
        send_op(OP_DDIFF, 1, 1, 0);
        send_op(OP_READ, 0, 2, 0);
        send_op(OP_SPARE_FIRST, 0, 2, COEF_MAX);
        send_op(OP_SPARE_FIRST + OP_W'(1), 2, 0, 0);
        send_op(OP_SPARE_LAST, 255, 255, COEF_MIN);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                idle_allowed = 1'b0;
            send_op(random_op(), random_index(), random_index(), random_coefficient());
        end
        req_ch.valid <= 1'b0;

        while (readbacks_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && readbacks_pending == 0)
            $display("** derivative_product_poly_engine: PASSED **");
        else
            $display("** derivative_product_poly_engine: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/dppe_pkg.sv
src/dppe_if.sv
src/dppe_bank_store.sv
src/derivative_product_poly_engine.sv
test/poly_table_checker.sv
test/tb_top.sv
